>>> src/pds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, constants and result layout of the PLL divider search unit.
// ----------------------------------------------------------------------------
package pds_pkg;

	// Shared multiplier operand and product widths.
	localparam int MUL_W  = 16;
	localparam int PROD_W = 2 * MUL_W;

	// Restoring divider: dividend is a 14-bit value shifted up by 8 (Q8).
	localparam int DIV_W     = 22;
	localparam int DIVISOR_W = 7;

	localparam int FREQ_W = 16;
	localparam int FB_W   = 8;
	localparam int VCO_W  = 13;
	localparam int ACH_W  = 20;
	localparam int ERR_W  = 13;
	localparam int WORD_W = 31;
	localparam int NUM_W  = 14;
	localparam int X_W    = 22;

	// Feedback multiplier limits expressed on a*b*r*f.
	localparam logic [22:0] PROD_MIN = 23'd25;
	localparam logic [22:0] PROD_LIM = 23'd6275;

	// floor(p/25) == (p*5243) >> 17 for every p below PROD_LIM.
	localparam logic [MUL_W-1:0] RECIP_25 = 16'd5243;
	localparam int RECIP_SHIFT = 17;

	// Oscillator limits in half units.
	localparam logic [13:0] VCO_MIN    = 14'd4000;
	localparam logic [13:0] VCO_MAX    = 14'd6400;
	localparam logic [13:0] VCO_MAX_R2 = 14'd6250;
	localparam logic [VCO_W-1:0] VCO_BAND = 13'd4800;

	// Bit positions of the result fields in tdata.
	localparam int OFS_REF  = 0;
	localparam int OFS_FB   = 2;
	localparam int OFS_A    = 10;
	localparam int OFS_B    = 13;
	localparam int OFS_VCO  = 16;
	localparam int OFS_ACH  = 29;
	localparam int OFS_ERR  = 49;
	localparam int OFS_WORD = 62;
	localparam int TDATA_W  = 96;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_FREQ = 2'd1,
		STAT_NO_SOL   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_AB,
		S_PROD,
		S_FB,
		S_VCO,
		S_NUM,
		S_X1,
		S_X2,
		S_X3,
		S_CMP,
		S_FIN,
		S_DIV_ACH,
		S_DIV_ERR,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

>>> src/pll_divider_search_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pll_divider_search_unit
// Searches reference, feedback and post divider settings for a requested
// clock frequency and returns the best setting with its packed register word.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The unit walks the 56
// candidate settings in order (reference divider 2 then 1, b from 1 to 7,
// a from b to 7) on one shared 16x16 multiplier, then, if a setting was
// kept, forms the achieved frequency and the error in Q8 with a bit-serial
// divider. For any one frequency only a narrow band of a*b products passes
// the oscillator check, at most six per reference divider, and a setting
// within 0.1 of the target stops the search early. A zero frequency goes
// straight to the output without a search, and its result transaction is
// offered once the output register is free. The input is not ready while a
// search runs; a finished result waits in the output register while the
// next transaction is taken.
module pll_divider_search_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [15:0] frequency
	input  logic [15:0]                     s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] ref_div, [9:2] fb_mult, [12:10] post_div_a, [15:13] post_div_b,
	// [28:16] vco_half_units, [48:29] achieved_q8, [61:49] error_q8,
	// [92:62] pll_word, [95:93] zero
	output logic [pds_pkg::TDATA_W-1:0]     m_tdata,
	// [1:0] status
	output logic [1:0]                      m_tuser
);

	pds_pkg::state_t  state_q, state_nx;
	pds_pkg::status_t stat_q;

	logic [pds_pkg::FREQ_W-1:0]   f_q;
	logic [1:0]                   r_q;
	logic [2:0]                   a_q, b_q;
	logic [6:0]                   den_q;
	logic [pds_pkg::FB_W-1:0]     fb_q;
	logic [pds_pkg::VCO_W-1:0]    vco_q;
	logic [pds_pkg::NUM_W-1:0]    num_q;
	logic [pds_pkg::X_W-1:0]      x1_q, x2_q;
	logic                         have_q;

	logic [1:0]                   k_r_q;
	logic [2:0]                   k_a_q, k_b_q;
	logic [pds_pkg::FB_W-1:0]     k_fb_q;
	logic [pds_pkg::VCO_W-1:0]    k_vco_q;
	logic [pds_pkg::NUM_W-1:0]    k_num_q;
	logic [6:0]                   k_den_q;
	logic [pds_pkg::ACH_W-1:0]    ach_q;
	logic [pds_pkg::ERR_W-1:0]    err_q;

	logic                         m_tvalid_q;
	logic [pds_pkg::TDATA_W-1:0]  m_tdata_q;
	logic [1:0]                   m_tuser_q;

	logic [pds_pkg::MUL_W-1:0]    mul_a, mul_b;
	logic [pds_pkg::PROD_W-1:0]   mul_prod;
	logic                         div_start, div_done;
	logic [pds_pkg::DIV_W-1:0]    div_dividend, div_quo;

	logic [5:0]                   ab;
	logic [6:0]                   abr;
	logic [22:0]                  prod;
	logic                         prod_bad;
	logic [pds_pkg::FB_W-1:0]     fb;
	logic [13:0]                  fb_ext, vco25, vco_c;
	logic                         vco_bad;
	logic [23:0]                  tgt, vco_ext, diff;
	logic [13:0]                  x3;
	logic [25:0]                  x1_ext, x2_ext, lhs, rhs;
	logic [17:0]                  num_ext, num10;
	logic                         keep, close, last_cand, leave, finish, out_free;
	logic [pds_pkg::WORD_W-1:0]   word;
	logic [2:0]                   a_m1, b_m1;

	pds_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_prod)
	);

	pds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (k_den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Candidate arithmetic around the shared multiplier.
	assign ab       = mul_prod[5:0];
	assign abr      = (r_q == 2'd2) ? {ab, 1'b0} : {1'b0, ab};
	assign prod     = mul_prod[22:0];
	assign prod_bad = (prod < pds_pkg::PROD_MIN) || (prod >= pds_pkg::PROD_LIM);
	assign fb       = mul_prod[pds_pkg::RECIP_SHIFT +: pds_pkg::FB_W];
	assign fb_ext   = {6'b0, fb};
	assign vco25    = (fb_ext << 4) + (fb_ext << 3) + fb_ext;
	assign vco_c    = (r_q == 2'd2) ? vco25 : {vco25[12:0], 1'b0};
	assign vco_bad  = (vco_c < pds_pkg::VCO_MIN) || (vco_c > pds_pkg::VCO_MAX) ||
		((r_q == 2'd2) && (vco_c > pds_pkg::VCO_MAX_R2));
	assign tgt      = mul_prod[23:0];
	assign vco_ext  = {11'b0, vco_q};
	assign diff     = (tgt >= vco_ext) ? (tgt - vco_ext) : (vco_ext - tgt);
	assign x3       = mul_prod[13:0];

	// New error below kept error plus 1/10, cross-multiplied.
	assign x1_ext = {4'b0, x1_q};
	assign x2_ext = {4'b0, x2_q};
	assign lhs    = (x1_ext << 3) + (x1_ext << 1);
	assign rhs    = (x2_ext << 3) + (x2_ext << 1) + {12'b0, x3};
	assign keep   = !have_q || (lhs < rhs);

	assign num_ext = {4'b0, num_q};
	assign num10   = (num_ext << 3) + (num_ext << 1);
	assign close   = num10 < {11'b0, den_q};

	assign last_cand = (r_q == 2'd1) && (b_q == 3'd7) && (a_q == 3'd7);
	assign leave     = ((state_q == pds_pkg::S_FB) && prod_bad) ||
		((state_q == pds_pkg::S_VCO) && vco_bad) || (state_q == pds_pkg::S_CMP);
	assign finish    = last_cand || ((state_q == pds_pkg::S_CMP) && keep && close);
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pds_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_nx = (s_tdata == '0) ? pds_pkg::S_OUT : pds_pkg::S_AB;
				end
			end
			pds_pkg::S_AB:   state_nx = pds_pkg::S_PROD;
			pds_pkg::S_PROD: state_nx = pds_pkg::S_FB;
			pds_pkg::S_FB: begin
				if (prod_bad) begin
					state_nx = finish ? pds_pkg::S_FIN : pds_pkg::S_AB;
				end else begin
					state_nx = pds_pkg::S_VCO;
				end
			end
			pds_pkg::S_VCO: begin
				if (vco_bad) begin
					state_nx = finish ? pds_pkg::S_FIN : pds_pkg::S_AB;
				end else begin
					state_nx = pds_pkg::S_NUM;
				end
			end
			pds_pkg::S_NUM:  state_nx = have_q ? pds_pkg::S_X1 : pds_pkg::S_CMP;
			pds_pkg::S_X1:   state_nx = pds_pkg::S_X2;
			pds_pkg::S_X2:   state_nx = pds_pkg::S_X3;
			pds_pkg::S_X3:   state_nx = pds_pkg::S_CMP;
			pds_pkg::S_CMP:  state_nx = finish ? pds_pkg::S_FIN : pds_pkg::S_AB;
			pds_pkg::S_FIN:  state_nx = have_q ? pds_pkg::S_DIV_ACH : pds_pkg::S_OUT;
			pds_pkg::S_DIV_ACH: begin
				if (div_done) begin
					state_nx = pds_pkg::S_DIV_ERR;
				end
			end
			pds_pkg::S_DIV_ERR: begin
				if (div_done) begin
					state_nx = pds_pkg::S_OUT;
				end
			end
			pds_pkg::S_OUT: begin
				if (out_free) begin
					state_nx = pds_pkg::S_IDLE;
				end
			end
			default: state_nx = pds_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = (state_q == pds_pkg::S_IDLE);
		mul_a        = '0;
		mul_b        = '0;
		div_start    = ((state_q == pds_pkg::S_FIN) && have_q) ||
			((state_q == pds_pkg::S_DIV_ACH) && div_done);
		div_dividend = (state_q == pds_pkg::S_FIN) ? {1'b0, k_vco_q, 8'b0} : {k_num_q, 8'b0};
		unique case (state_q)
			pds_pkg::S_AB: begin
				mul_a = {13'b0, a_q};
				mul_b = {13'b0, b_q};
			end
			pds_pkg::S_PROD: begin
				mul_a = {9'b0, abr};
				mul_b = f_q;
			end
			pds_pkg::S_FB: begin
				mul_a = {3'b0, prod[12:0]};
				mul_b = pds_pkg::RECIP_25;
			end
			pds_pkg::S_VCO: begin
				mul_a = {9'b0, den_q};
				mul_b = f_q;
			end
			pds_pkg::S_X1: begin
				mul_a = {2'b0, num_q};
				mul_b = {9'b0, k_den_q};
			end
			pds_pkg::S_X2: begin
				mul_a = {2'b0, k_num_q};
				mul_b = {9'b0, den_q};
			end
			pds_pkg::S_X3: begin
				mul_a = {9'b0, den_q};
				mul_b = {9'b0, k_den_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pds_pkg::S_IDLE;
			have_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if ((state_q == pds_pkg::S_IDLE) && s_tvalid) begin
				have_q <= 1'b0;
			end else if ((state_q == pds_pkg::S_CMP) && keep) begin
				have_q <= 1'b1;
			end
			if ((state_q == pds_pkg::S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign a_m1 = k_a_q - 3'd1;
	assign b_m1 = k_b_q - 3'd1;
	assign word = {1'b1, 1'b0, (k_vco_q >= pds_pkg::VCO_BAND), 4'b0, k_fb_q, 6'b0,
		k_r_q, 1'b0, a_m1, 1'b0, b_m1};

	always_ff @(posedge clk) begin
		unique case (state_q)
			pds_pkg::S_IDLE: begin
				if (s_tvalid) begin
					f_q    <= s_tdata;
					r_q    <= 2'd2;
					b_q    <= 3'd1;
					a_q    <= 3'd1;
					stat_q <= (s_tdata == '0) ? pds_pkg::STAT_BAD_FREQ : pds_pkg::STAT_OK;
				end
			end
			pds_pkg::S_PROD: den_q <= {ab, 1'b0};
			pds_pkg::S_VCO: begin
				fb_q  <= fb;
				vco_q <= vco_c[pds_pkg::VCO_W-1:0];
			end
			pds_pkg::S_NUM: num_q <= diff[pds_pkg::NUM_W-1:0];
			pds_pkg::S_X2:  x1_q <= mul_prod[pds_pkg::X_W-1:0];
			pds_pkg::S_X3:  x2_q <= mul_prod[pds_pkg::X_W-1:0];
			pds_pkg::S_CMP: begin
				if (keep) begin
					k_r_q   <= r_q;
					k_a_q   <= a_q;
					k_b_q   <= b_q;
					k_fb_q  <= fb_q;
					k_vco_q <= vco_q;
					k_num_q <= num_q;
					k_den_q <= den_q;
				end
			end
			pds_pkg::S_FIN: begin
				if (!have_q) begin
					stat_q <= pds_pkg::STAT_NO_SOL;
				end
			end
			pds_pkg::S_DIV_ACH: begin
				if (div_done) begin
					ach_q <= div_quo[pds_pkg::ACH_W-1:0];
				end
			end
			pds_pkg::S_DIV_ERR: begin
				if (div_done) begin
					err_q <= div_quo[pds_pkg::ERR_W-1:0];
				end
			end
			pds_pkg::S_OUT: begin
				if (out_free) begin
					m_tuser_q <= stat_q;
					if (stat_q == pds_pkg::STAT_OK) begin
						m_tdata_q <= {3'b0, word, err_q, ach_q, k_vco_q, k_b_q, k_a_q,
							k_fb_q, k_r_q};
					end else begin
						m_tdata_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase

		// Step to the next candidate: a runs from b to 7 inside b, b inside r.
		if (leave && !last_cand) begin
			if (a_q != 3'd7) begin
				a_q <= a_q + 3'd1;
			end else if (b_q != 3'd7) begin
				b_q <= b_q + 3'd1;
				a_q <= b_q + 3'd1;
			end else begin
				r_q <= 2'd1;
				b_q <= 3'd1;
				a_q <= 3'd1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

>>> src/pds_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pds_mul (
	input  logic                         clk,
	input  logic [pds_pkg::MUL_W-1:0]    op_a,
	input  logic [pds_pkg::MUL_W-1:0]    op_b,
	output logic [pds_pkg::PROD_W-1:0]   prod
);

	logic [pds_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= {{pds_pkg::MUL_W{1'b0}}, op_a} * {{pds_pkg::MUL_W{1'b0}}, op_b};
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

>>> src/pds_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pds_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pds_pkg::DIV_W-1:0]       dividend,
	input  logic [pds_pkg::DIVISOR_W-1:0]   divisor,
	output logic                            done,
	output logic [pds_pkg::DIV_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(pds_pkg::DIV_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pds_pkg::DIV_W - 1);

	logic [pds_pkg::DIVISOR_W-1:0] rem_q;
	logic [pds_pkg::DIV_W-1:0]     quo_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [pds_pkg::DIVISOR_W:0]   trial;
	logic [pds_pkg::DIVISOR_W:0]   diff;
	logic                          fits;

	assign trial = {rem_q, quo_q[pds_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[pds_pkg::DIVISOR_W-1:0] : trial[pds_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[pds_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> src/pds_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks of the PLL divider search unit, bound to the top level.
// ----------------------------------------------------------------------------
module pds_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [pds_pkg::TDATA_W-1:0]  m_tdata,
	input logic [1:0]                   m_tuser
);

	// A held result must not change while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("held result changed");

	// Only one search runs at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a search runs");

	// A failed search carries no setting.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != pds_pkg::STAT_OK) |-> (m_tdata == '0))
		else $error("failed result carries data");

	// A good result has legal dividers and a register word whose feedback and reference fields match them.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == pds_pkg::STAT_OK) |->
		((m_tdata[pds_pkg::OFS_REF +: 2] == 2'd1) || (m_tdata[pds_pkg::OFS_REF +: 2] == 2'd2)) &&
		(m_tdata[pds_pkg::OFS_B +: 3] != 3'd0) &&
		(m_tdata[pds_pkg::OFS_A +: 3] >= m_tdata[pds_pkg::OFS_B +: 3]) &&
		m_tdata[pds_pkg::OFS_WORD + 30] &&
		(m_tdata[pds_pkg::OFS_WORD + 16 +: 8] == m_tdata[pds_pkg::OFS_FB +: 8]) &&
		(m_tdata[pds_pkg::OFS_WORD + 8 +: 2] == m_tdata[pds_pkg::OFS_REF +: 2]))
		else $error("inconsistent setting in result");

endmodule

bind pll_divider_search_unit pds_checker u_pds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
